@@ hdl/jtp_pkg.sv @@
// ----------------------------------------------------------------------------
// jtp_pkg
// Shared widths, payload types and helpers for the Jones triple product.
// ----------------------------------------------------------------------------
package jtp_pkg;

	localparam int IN_W    = 16;            // input component, Q2.14
	localparam int FRAC    = IN_W - 2;
	localparam int OUT_W   = 24;            // output component, Q10.14
	localparam int ROW_W   = 64;            // one matrix row per field
	localparam int PROD_W  = 2 * IN_W;      // a * b component product
	localparam int AB_W    = PROD_W + 2;    // exact A*B element component
	localparam int PROD2_W = AB_W + IN_W;   // ab * c component product
	localparam int SUM_W   = PROD2_W + 2;   // exact A*B*C^H component
	localparam int RND_SH  = 2 * FRAC;
	localparam int LATENCY = 6;             // request to result strobe

	typedef logic signed [IN_W-1:0] comp_t;

	typedef struct packed {
		comp_t re;
		comp_t im;
	} cpx_t;

	typedef struct packed {
		logic signed [AB_W-1:0] re;
		logic signed [AB_W-1:0] im;
	} ab_cpx_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} sum_cpx_t;

	typedef cpx_t     [1:0][1:0] mat_t;
	typedef ab_cpx_t  [1:0][1:0] ab_mat_t;
	typedef sum_cpx_t [1:0][1:0] sum_mat_t;

	typedef struct packed {
		logic       vld;
		logic [3:0] mask;
	} ctl_t;

	typedef struct packed {
		logic [ROW_W-1:0] left_row0;
		logic [ROW_W-1:0] left_row1;
		logic [ROW_W-1:0] mid_row0;
		logic [ROW_W-1:0] mid_row1;
		logic [ROW_W-1:0] right_row0;
		logic [ROW_W-1:0] right_row1;
		logic [3:0]       left_dirty;
		logic [3:0]       mid_dirty;
		logic [3:0]       right_dirty;
	} req_t;

	typedef struct packed {
		logic [2*OUT_W-1:0] out00;
		logic [2*OUT_W-1:0] out01;
		logic [2*OUT_W-1:0] out10;
		logic [2*OUT_W-1:0] out11;
		logic [3:0]         computed_mask;
	} res_t;

	// Lanes from high to low: (r,0) re, (r,0) im, (r,1) re, (r,1) im.
	function automatic cpx_t lane_pair(input logic [ROW_W-1:0] row, input logic col);
		cpx_t c;
		if (col) begin
			c.re = row[IN_W +: IN_W];
			c.im = row[0 +: IN_W];
		end else begin
			c.re = row[3*IN_W +: IN_W];
			c.im = row[2*IN_W +: IN_W];
		end
		return c;
	endfunction

	// Result elements that depend on a dirty input element.
	function automatic logic [3:0] sel_mask(input logic [3:0] ld, input logic [3:0] md,
			input logic [3:0] rd);
		logic [3:0] m;
		m = '0;
		if (md != 4'd0) begin
			m = 4'hF;
		end else begin
			if (ld[1:0] != 2'd0) m = m | 4'b0011;
			if (ld[3:2] != 2'd0) m = m | 4'b1100;
			if (rd[1:0] != 2'd0) m = m | 4'b0101;
			if (rd[3:2] != 2'd0) m = m | 4'b1010;
		end
		return m;
	endfunction

endpackage

@@ hdl/jones_triple_product_top.sv @@
// ----------------------------------------------------------------------------
// jones_triple_product_top
// Fully pipelined A * B * C^H over complex 2x2 matrices with dirty masks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on req and raise start; it is taken at the rising edge
//   where start is high and busy is low. busy stays low, so a new request
//   may be taken at every clock edge.
//   Each request yields one result on res, with done high for exactly one
//   cycle, from the output register. Results come out in request
//   order, one per cycle at most.
//   Throughput is one request per clock; the six register stages are unpack,
//   A*B products, A*B sums, (A*B)*C^H products, sums with rounding half, and
//   saturation into the output register.
//   Elements that no dirty input bit selects come out as zero and clear in
//   computed_mask.
//   Reset (arst_n low) clears all stage valid bits, so done stays low until
//   requests arrive; payload registers are not reset.
//   The receiver cannot stall: res is valid only in the cycle done is high.
// ----------------------------------------------------------------------------
module jones_triple_product_top import jtp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t res
);

	ctl_t     ctl_s1, ctl_s3, ctl_s5;
	mat_t     a_s1, b_s1, c_s1, c_s3;
	ab_mat_t  ab_s3;
	sum_mat_t sum_s5;

	assign busy = 1'b0;

	jtp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start & ~busy),
		.req    (req),
		.ctl_s1 (ctl_s1),
		.a_s1   (a_s1),
		.b_s1   (b_s1),
		.c_s1   (c_s1)
	);

	jtp_ab u_ab (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_s1),
		.a_in   (a_s1),
		.b_in   (b_s1),
		.c_in   (c_s1),
		.ctl_s3 (ctl_s3),
		.ab_s3  (ab_s3),
		.c_s3   (c_s3)
	);

	jtp_abc u_abc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_s3),
		.ab_in  (ab_s3),
		.c_in   (c_s3),
		.ctl_s5 (ctl_s5),
		.sum_s5 (sum_s5)
	);

	jtp_finish u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (ctl_s5),
		.sum_in (sum_s5),
		.done   (done),
		.res    (res)
	);

`ifndef SYNTH
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching request");

	a_mid_dirty_all: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(req.mid_dirty != 4'd0, LATENCY) |-> res.computed_mask == 4'hF)
		else $error("dirty B did not select all elements");

	a_skipped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.computed_mask[0] || res.out00 == '0)
			&& (res.computed_mask[1] || res.out01 == '0)
			&& (res.computed_mask[2] || res.out10 == '0)
			&& (res.computed_mask[3] || res.out11 == '0))
		else $error("skipped element is not zero");

	a_no_dirty_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(req.left_dirty == 4'd0 && req.mid_dirty == 4'd0
			&& req.right_dirty == 4'd0, LATENCY) |-> res.computed_mask == 4'd0)
		else $error("element computed with no dirty input");
`endif

endmodule

@@ hdl/jtp_front.sv @@
// ----------------------------------------------------------------------------
// jtp_front
// Stage 1: unpack the three matrices and decide which elements to compute.
// ----------------------------------------------------------------------------
module jtp_front import jtp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  req_t req,
	output ctl_t ctl_s1,
	output mat_t a_s1,
	output mat_t b_s1,
	output mat_t c_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= take;
			ctl_s1.mask <= sel_mask(req.left_dirty, req.mid_dirty, req.right_dirty);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 2; j++) begin
			a_s1[0][j] <= lane_pair(req.left_row0, j[0]);
			a_s1[1][j] <= lane_pair(req.left_row1, j[0]);
			b_s1[0][j] <= lane_pair(req.mid_row0, j[0]);
			b_s1[1][j] <= lane_pair(req.mid_row1, j[0]);
			c_s1[0][j] <= lane_pair(req.right_row0, j[0]);
			c_s1[1][j] <= lane_pair(req.right_row1, j[0]);
		end
	end

endmodule

@@ hdl/jtp_ab.sv @@
// ----------------------------------------------------------------------------
// jtp_ab
// Stages 2-3: exact complex product A*B, component products then sums.
// ----------------------------------------------------------------------------
module jtp_ab import jtp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl_in,
	input  mat_t    a_in,
	input  mat_t    b_in,
	input  mat_t    c_in,
	output ctl_t    ctl_s3,
	output ab_mat_t ab_s3,
	output mat_t    c_s3
);

	ctl_t ctl_s2;
	mat_t c_s2;
	// [i][j][k]: a[i][k] times b[k][j]
	logic signed [PROD_W-1:0] rr_s2 [2][2][2];
	logic signed [PROD_W-1:0] ii_s2 [2][2][2];
	logic signed [PROD_W-1:0] ri_s2 [2][2][2];
	logic signed [PROD_W-1:0] ir_s2 [2][2][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s2 <= c_in;
		c_s3 <= c_s2;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 2; k++) begin
					rr_s2[i][j][k] <= $signed(a_in[i][k].re) * $signed(b_in[k][j].re);
					ii_s2[i][j][k] <= $signed(a_in[i][k].im) * $signed(b_in[k][j].im);
					ri_s2[i][j][k] <= $signed(a_in[i][k].re) * $signed(b_in[k][j].im);
					ir_s2[i][j][k] <= $signed(a_in[i][k].im) * $signed(b_in[k][j].re);
				end
				ab_s3[i][j].re <= AB_W'(rr_s2[i][j][0]) - AB_W'(ii_s2[i][j][0])
					+ AB_W'(rr_s2[i][j][1]) - AB_W'(ii_s2[i][j][1]);
				ab_s3[i][j].im <= AB_W'(ri_s2[i][j][0]) + AB_W'(ir_s2[i][j][0])
					+ AB_W'(ri_s2[i][j][1]) + AB_W'(ir_s2[i][j][1]);
			end
		end
	end

endmodule

@@ hdl/jtp_abc.sv @@
// ----------------------------------------------------------------------------
// jtp_abc
// Stages 4-5: (A*B)*C^H, component products then exact sums plus one half.
// ----------------------------------------------------------------------------
module jtp_abc import jtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_t     ctl_in,
	input  ab_mat_t  ab_in,
	input  mat_t     c_in,
	output ctl_t     ctl_s5,
	output sum_mat_t sum_s5
);

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (RND_SH - 1);

	ctl_t ctl_s4;
	// [i][j][k]: ab[i][k] times conj(c[j][k])
	logic signed [PROD2_W-1:0] rr_s4 [2][2][2];
	logic signed [PROD2_W-1:0] ii_s4 [2][2][2];
	logic signed [PROD2_W-1:0] ir_s4 [2][2][2];
	logic signed [PROD2_W-1:0] ri_s4 [2][2][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_in;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 2; k++) begin
					rr_s4[i][j][k] <= $signed(ab_in[i][k].re) * $signed(c_in[j][k].re);
					ii_s4[i][j][k] <= $signed(ab_in[i][k].im) * $signed(c_in[j][k].im);
					ir_s4[i][j][k] <= $signed(ab_in[i][k].im) * $signed(c_in[j][k].re);
					ri_s4[i][j][k] <= $signed(ab_in[i][k].re) * $signed(c_in[j][k].im);
				end
				// fold the rounding half in here to keep stage 6 short
				sum_s5[i][j].re <= SUM_W'(rr_s4[i][j][0]) + SUM_W'(ii_s4[i][j][0])
					+ SUM_W'(rr_s4[i][j][1]) + SUM_W'(ii_s4[i][j][1]) + HALF;
				sum_s5[i][j].im <= SUM_W'(ir_s4[i][j][0]) - SUM_W'(ri_s4[i][j][0])
					+ SUM_W'(ir_s4[i][j][1]) - SUM_W'(ri_s4[i][j][1]) + HALF;
			end
		end
	end

endmodule

@@ hdl/jtp_finish.sv @@
// ----------------------------------------------------------------------------
// jtp_finish
// Stage 6: drop fraction bits, saturate, zero skipped elements, register out.
// ----------------------------------------------------------------------------
module jtp_finish import jtp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_t     ctl_in,
	input  sum_mat_t sum_in,
	output logic     done,
	output res_t     res
);

	localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (OUT_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

	function automatic logic [OUT_W-1:0] clip(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] sh;
		sh = v >>> RND_SH;
		if (sh > SAT_MAX)
			return SAT_MAX[OUT_W-1:0];
		else if (sh < SAT_MIN)
			return SAT_MIN[OUT_W-1:0];
		else
			return sh[OUT_W-1:0];
	endfunction

	function automatic logic [2*OUT_W-1:0] pack(input sum_cpx_t s, input logic keep);
		return keep ? {clip(s.re), clip(s.im)} : '0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= ctl_in.vld;
	end

	always_ff @(posedge clk) begin
		res.out00         <= pack(sum_in[0][0], ctl_in.mask[0]);
		res.out01         <= pack(sum_in[0][1], ctl_in.mask[1]);
		res.out10         <= pack(sum_in[1][0], ctl_in.mask[2]);
		res.out11         <= pack(sum_in[1][1], ctl_in.mask[3]);
		res.computed_mask <= ctl_in.mask;
	end

endmodule
